// File: hdl/ssem_pkg.sv
// Shared types and constants for the SSEM instruction step core.
// No dependencies; compile first.
package ssem_pkg;

  localparam int WORD_W          = 32;
  localparam int CMD_W           = 2;
  localparam int ADDR_W          = 5;
  localparam int ADDR_BITS_DEF   = 5;
  localparam int STORE_WORDS_DEF = 32;

  // Serial datapath: one digit per cycle through the adder
  localparam int DIGIT_W   = 8;
  localparam int N_DIG     = WORD_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(N_DIG);

  // Function field of the present instruction
  localparam int FUNC_LSB = 13;
  localparam int FUNC_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTORE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_JMP     = 3'd0,
    FN_JRP     = 3'd1,
    FN_LDN     = 3'd2,
    FN_STO     = 3'd3,
    FN_SUB     = 3'd4,
    FN_SUB_ALT = 3'd5,
    FN_CMP     = 3'd6,
    FN_STP     = 3'd7
  } func_t;

endpackage

// File: hdl/ssem_if.sv
// Command and result channel interfaces for the SSEM instruction step core.
// Depends on ssem_pkg.
interface ssem_in_if;
  import ssem_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] data;

  modport source (output valid, output cmd, output addr, output data, input ready);
  modport sink   (input valid, input cmd, input addr, input data, output ready);
endinterface

interface ssem_out_if;
  import ssem_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] accumulator;
  logic [WORD_W-1:0] control_instr;
  logic [WORD_W-1:0] present_instr;
  logic              halted;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, output accumulator, output control_instr,
                  output present_instr, output halted, output read_data, input ready);
  modport sink   (input valid, input accumulator, input control_instr,
                  input present_instr, input halted, input read_data, output ready);
endinterface

// File: hdl/ssem_instruction_step_core.sv
// Top level of the SSEM instruction step core: sequencer, serial adder, store
// and saved program copy. Depends on ssem_pkg and ssem_if.
//
// Usage:
//   in_ch  carries one command per transaction (step, load program word,
//          restore program, read store word). A transaction is taken at a
//          rising edge with valid and ready both high.
//   out_ch returns exactly one result transaction per command: accumulator,
//          CI, PI, halted flag and read data (zero unless a read).
// Sequence of a step: CI increment in the 8-bit digit-serial adder, instruction
//   fetch and operand fetch through the store's registered read port, then for
//   JRP/LDN/SUB/CMP the arithmetic of the function in the same adder; JMP, STO
//   and STP finish without it. A restore copies the program copy back into the
//   store word by word. One command is in work at a time; the next is taken in
//   the cycle after the previous result is loaded into the output register.
// Reset: rst_n (synchronous) clears the registers and then runs a clearing
//   pass over every word of the store and program copy, during which
//   in_ch.ready stays low.
// Stall: a finished result waits in the output register; the core still takes
//   a new command, but holds its result until out_ch drains the previous one.
module ssem_instruction_step_core #(
  parameter int ADDR_BITS   = ssem_pkg::ADDR_BITS_DEF,
  parameter int STORE_WORDS = ssem_pkg::STORE_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssem_in_if.sink   in_ch,
  ssem_out_if.source out_ch
);
  import ssem_pkg::*;

  localparam int MEM_AW = $clog2(STORE_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INC,
    S_FETCH,
    S_DECODE,
    S_OPER,
    S_EXEC,
    S_ALU,
    S_READ,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } state_t;

  // Word index is valid only below the store depth
  function automatic logic in_store(input logic [ADDR_BITS-1:0] a);
    return 32'(a) < 32'(STORE_WORDS);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [ADDR_BITS-1:0] a);
    return MEM_AW'(a);
  endfunction

  state_t state_r;
  cmd_t   cmd_r;

  // Architectural registers
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] ci_r;
  logic [WORD_W-1:0] pi_r;
  logic              halted_r;

  // Serial adder: a + b + carry, one digit a cycle, result shifts into add_a_r
  logic [WORD_W-1:0]    add_a_r;
  logic [WORD_W-1:0]    add_b_r;
  logic                 add_c_r;
  logic [DIG_CNT_W-1:0] dig_cnt_r;
  logic                 add_to_acc_r;
  logic [DIGIT_W:0]     dsum;
  logic [WORD_W-1:0]    add_res;
  logic                 dig_last;

  // Memory ports
  logic [WORD_W-1:0] store_mem [STORE_WORDS];
  logic [WORD_W-1:0] copy_mem  [STORE_WORDS];
  logic [MEM_AW-1:0] rd_addr_r;
  logic              rd_ok_r;
  logic [WORD_W-1:0] st_q;
  logic [WORD_W-1:0] cp_q;
  logic [MEM_AW-1:0] sw_idx_r;
  logic              st_we;
  logic [MEM_AW-1:0] st_wa;
  logic [WORD_W-1:0] st_wd;
  logic              cp_we;
  logic [MEM_AW-1:0] cp_wa;
  logic [WORD_W-1:0] cp_wd;

  // Output register
  logic              out_valid_r;
  logic [WORD_W-1:0] out_acc_r;
  logic [WORD_W-1:0] out_ci_r;
  logic [WORD_W-1:0] out_pi_r;
  logic              out_halted_r;
  logic [WORD_W-1:0] out_rd_r;

  logic                 in_fire;
  cmd_t                 in_cmd;
  logic [ADDR_BITS-1:0] in_idx;
  logic                 in_ok;
  logic [WORD_W-1:0]    opnd;
  func_t                fn;
  logic [WORD_W-1:0]    pi_fetch;
  logic                 sweep_last;
  logic                 out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign in_idx      = ADDR_BITS'(in_ch.addr);
  assign in_ok       = in_store(in_idx);

  assign opnd       = rd_ok_r ? st_q : '0;
  assign pi_fetch   = rd_ok_r ? st_q : '0;
  assign fn         = func_t'(pi_r[FUNC_LSB +: FUNC_W]);
  assign sweep_last = (sw_idx_r == MEM_AW'(STORE_WORDS - 1));
  assign out_free   = !out_valid_r || out_ch.ready;

  assign dsum     = {1'b0, add_a_r[DIGIT_W-1:0]} + {1'b0, add_b_r[DIGIT_W-1:0]}
                  + (DIGIT_W + 1)'(add_c_r);
  assign add_res  = {dsum[DIGIT_W-1:0], add_a_r[WORD_W-1:DIGIT_W]};
  assign dig_last = (dig_cnt_r == DIG_CNT_W'(N_DIG - 1));

  // Write port selection for both memories
  always_comb begin
    st_we = 1'b0;
    st_wa = sw_idx_r;
    st_wd = '0;
    cp_we = 1'b0;
    cp_wa = sw_idx_r;
    cp_wd = '0;
    case (state_r)
      S_CLEAR: begin
        st_we = 1'b1;
        cp_we = 1'b1;
      end
      S_COPY_WR: begin
        st_we = 1'b1;
        st_wd = cp_q;
      end
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_LOAD && in_ok) begin
          st_we = 1'b1;
          st_wa = mem_idx(in_idx);
          st_wd = in_ch.data;
          cp_we = 1'b1;
          cp_wa = mem_idx(in_idx);
          cp_wd = in_ch.data;
        end
      end
      S_EXEC: begin
        if (fn == FN_STO && rd_ok_r) begin
          st_we = 1'b1;
          st_wa = rd_addr_r;
          st_wd = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    st_q <= store_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cp_we) begin
      copy_mem[cp_wa] <= cp_wd;
    end
    cp_q <= copy_mem[sw_idx_r];
  end

  // Sequencer, architectural registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sw_idx_r    <= '0;
      acc_r       <= '0;
      ci_r        <= '0;
      pi_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop valid once drained, unless a new result is loaded this cycle
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      // Advance the serial adder in both adder states
      if (state_r == S_INC || state_r == S_ALU) begin
        add_a_r   <= add_res;
        add_b_r   <= add_b_r >> DIGIT_W;
        add_c_r   <= dsum[DIGIT_W];
        dig_cnt_r <= dig_cnt_r + DIG_CNT_W'(1);
      end

      unique case (state_r)
        S_CLEAR: begin
          sw_idx_r <= sw_idx_r + MEM_AW'(1);
          if (sweep_last) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            cmd_r     <= in_cmd;
            rd_addr_r <= mem_idx(in_idx);
            rd_ok_r   <= in_ok;
            unique case (in_cmd)
              CMD_STEP: begin
                if (halted_r) begin
                  state_r <= S_DONE;
                end else begin
                  add_a_r   <= ci_r;
                  add_b_r   <= '0;
                  add_c_r   <= 1'b1;
                  dig_cnt_r <= '0;
                  state_r   <= S_INC;
                end
              end
              CMD_LOAD: state_r <= S_DONE;
              CMD_RESTORE: begin
                acc_r    <= '0;
                ci_r     <= '0;
                pi_r     <= '0;
                halted_r <= 1'b0;
                sw_idx_r <= '0;
                state_r  <= S_COPY_RD;
              end
              CMD_READ: state_r <= S_READ;
            endcase
          end
        end

        S_INC: begin
          if (dig_last) begin
            ci_r      <= add_res;
            rd_addr_r <= mem_idx(add_res[ADDR_BITS-1:0]);
            rd_ok_r   <= in_store(add_res[ADDR_BITS-1:0]);
            state_r   <= S_FETCH;
          end
        end

        S_FETCH: state_r <= S_DECODE;

        S_DECODE: begin
          pi_r      <= pi_fetch;
          rd_addr_r <= mem_idx(pi_fetch[ADDR_BITS-1:0]);
          rd_ok_r   <= in_store(pi_fetch[ADDR_BITS-1:0]);
          state_r   <= S_OPER;
        end

        S_OPER: state_r <= S_EXEC;

        S_EXEC: begin
          dig_cnt_r <= '0;
          unique case (fn) inside
            FN_JMP: begin
              ci_r    <= opnd;
              state_r <= S_DONE;
            end
            FN_JRP: begin
              add_a_r      <= ci_r;
              add_b_r      <= opnd;
              add_c_r      <= 1'b0;
              add_to_acc_r <= 1'b0;
              state_r      <= S_ALU;
            end
            FN_LDN: begin
              add_a_r      <= '0;
              add_b_r      <= ~opnd;
              add_c_r      <= 1'b1;
              add_to_acc_r <= 1'b1;
              state_r      <= S_ALU;
            end
            FN_STO: state_r <= S_DONE;
            FN_SUB, FN_SUB_ALT: begin
              add_a_r      <= acc_r;
              add_b_r      <= ~opnd;
              add_c_r      <= 1'b1;
              add_to_acc_r <= 1'b1;
              state_r      <= S_ALU;
            end
            FN_CMP: begin
              // skip the next instruction when the accumulator is negative
              add_a_r      <= ci_r;
              add_b_r      <= '0;
              add_c_r      <= acc_r[WORD_W-1];
              add_to_acc_r <= 1'b0;
              state_r      <= S_ALU;
            end
            FN_STP: begin
              halted_r <= 1'b1;
              state_r  <= S_DONE;
            end
          endcase
        end

        S_ALU: begin
          if (dig_last) begin
            if (add_to_acc_r) begin
              acc_r <= add_res;
            end else begin
              ci_r <= add_res;
            end
            state_r <= S_DONE;
          end
        end

        S_READ: state_r <= S_DONE;

        S_COPY_RD: state_r <= S_COPY_WR;

        S_COPY_WR: begin
          sw_idx_r <= sw_idx_r + MEM_AW'(1);
          state_r  <= sweep_last ? S_DONE : S_COPY_RD;
        end

        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_acc_r    <= acc_r;
            out_ci_r     <= ci_r;
            out_pi_r     <= pi_r;
            out_halted_r <= halted_r;
            out_rd_r     <= (cmd_r == CMD_READ && rd_ok_r) ? st_q : '0;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accumulator   = out_acc_r;
  assign out_ch.control_instr = out_ci_r;
  assign out_ch.present_instr = out_pi_r;
  assign out_ch.halted        = out_halted_r;
  assign out_ch.read_data     = out_rd_r;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for ssem_instruction_step_core: directed program plus random programs.
// A command-level predictor in a small scoreboard class checks every result transaction.
// Depends on hdl/ssem_pkg.sv, hdl/ssem_if.sv and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssem_pkg::*;

  localparam int AB        = ADDR_BITS_DEF;
  localparam int WORDS     = STORE_WORDS_DEF;
  localparam int ITEM_GOAL = 625;   // directed and random commands, steps on a halted machine not counted
  localparam int DRAIN_MAX = 20000;

  // One result transaction as seen on out_ch
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] ci;
    logic [WORD_W-1:0] pi;
    logic              halted;
    logic [WORD_W-1:0] rdata;
  } step_result_t;

  // Machine image plus the queue of results still owed by the core.
  class step_scoreboard;
    logic [WORD_W-1:0] store_img [WORDS];
    logic [WORD_W-1:0] saved_prog[WORDS];
    logic [WORD_W-1:0] acc, ci, pi;
    logic              halted;
    step_result_t      owed[$];
    int                errors;
    int                n_checked;
    int                n_by_cmd [4];
    int                n_by_func[8];
    int                n_idle_steps;
    int                n_ci_wraps;

    function new();
      foreach (store_img[i]) begin
        store_img[i]  = '0;
        saved_prog[i] = '0;
      end
      acc = '0;
      ci = '0;
      pi = '0;
      halted = 1'b0;
      errors = 0;
      n_checked = 0;
      n_idle_steps = 0;
      n_ci_wraps = 0;
      foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
      foreach (n_by_func[i]) n_by_func[i] = 0;
    endfunction

    // Words past the end of the store read as zero
    function logic [WORD_W-1:0] word_at(logic [WORD_W-1:0] a);
      int unsigned idx;
      idx = a & ((1 << AB) - 1);
      return (idx < WORDS) ? store_img[idx] : '0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Advance the machine image by one accepted command and queue its result.
    function void note_command(cmd_t op, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d);
      step_result_t      r;
      logic [WORD_W-1:0] operand;
      int unsigned       idx;
      func_t             fn;
      r.rdata = '0;
      n_by_cmd[op]++;
      case (op)
        CMD_STEP: begin
          if (halted) begin
            n_idle_steps++;
          end else begin
            ci = ci + 1;
            if (ci == '0) n_ci_wraps++;
            pi = word_at(ci);
            fn = func_t'(pi[FUNC_LSB +: FUNC_W]);
            operand = word_at(pi);
            n_by_func[fn]++;
            case (fn)
              FN_JMP: ci = operand;
              FN_JRP: ci = ci + operand;
              FN_LDN: acc = '0 - operand;
              FN_STO: begin
                idx = pi & ((1 << AB) - 1);
                if (idx < WORDS) store_img[idx] = acc;
              end
              FN_SUB, FN_SUB_ALT: acc = acc - operand;
              FN_CMP: if (acc[WORD_W-1]) ci = ci + 1;
              FN_STP: halted = 1'b1;
            endcase
          end
        end
        CMD_LOAD: begin
          idx = a & ((1 << AB) - 1);
          if (idx < WORDS) begin
            store_img[idx]  = d;
            saved_prog[idx] = d;
          end
        end
        CMD_RESTORE: begin
          store_img = saved_prog;
          acc = '0;
          ci = '0;
          pi = '0;
          halted = 1'b0;
        end
        CMD_READ: r.rdata = word_at({{(WORD_W-ADDR_W){1'b0}}, a});
      endcase
      r.acc = acc;
      r.ci = ci;
      r.pi = pi;
      r.halted = halted;
      owed.push_back(r);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing pending, expected none, got %h", $time, got);
        return;
      end
      want = owed.pop_front();
      n_checked++;
      compare_field("accumulator", want.acc, got.acc);
      compare_field("control_instr", want.ci, got.ci);
      compare_field("present_instr", want.pi, got.pi);
      compare_field("halted", {31'b0, want.halted}, {31'b0, got.halted});
      compare_field("read_data", want.rdata, got.rdata);
    endfunction

    function void flag_leftovers();
      foreach (owed[i]) begin
        errors++;
        $display("%0t ns: missing result, expected %h, got none", $time, owed[i]);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ssem_in_if  in_ch ();
  ssem_out_if out_ch ();

  ssem_instruction_step_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  step_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int useful_cmds;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs on a handshake.
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Build an instruction word: function in bits 15..13, operand address in the low bits.
  function automatic logic [WORD_W-1:0] instr_word(logic [WORD_W-1:0] base, func_t fn,
                                                   int unsigned s);
    logic [WORD_W-1:0] w;
    w = base;
    w[FUNC_LSB +: FUNC_W] = fn;
    w[AB-1:0] = s[AB-1:0];
    return w;
  endfunction

  // Offer one command and hold it until the core takes it. valid stays high
  // after the transaction so a back-to-back command needs no extra edge.
  task automatic send_command(cmd_t op, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.addr  <= a;
    in_ch.data  <= d;
    do @(posedge clk); while (!in_ch.ready);
    // Steps on a halted machine change nothing; keep them out of the item count.
    if (!(op == CMD_STEP && sb.halted)) useful_cmds++;
    sb.note_command(op, a, d);
  endtask

  // Drop valid and hold off until every queued result has drained.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    send_command(cmd_t'($urandom_range(0, 3)), ADDR_W'($urandom), $urandom);
  endtask

  // Load a short program (mostly instruction-shaped words), optionally restart it,
  // then step through it with reads and an occasional stray command mixed in.
  task automatic run_random_program();
    int unsigned n_words, base, n_steps, r;
    logic [WORD_W-1:0] w;
    n_words = $urandom_range(2, 12);
    base = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 31);
    for (int k = 0; k < n_words; k++) begin
      w = $urandom;
      if ($urandom_range(0, 99) < 75)
        w = instr_word(w, func_t'($urandom_range(0, 7)), $urandom_range(0, 31));
      send_command(CMD_LOAD, ADDR_W'(base + k), w);
    end
    if ($urandom_range(0, 99) < 60) send_command(CMD_RESTORE, '0, $urandom);
    n_steps = $urandom_range(4, 24);
    for (int k = 0; k < n_steps; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12)      send_command(CMD_READ, ADDR_W'($urandom), $urandom);
      else if (r < 16) send_random_cmd();
      else             send_command(CMD_STEP, ADDR_W'($urandom), $urandom);
      // Stop shortly after a halt, sometimes probing it with one more step first.
      if (sb.halted) begin
        if ($urandom_range(0, 1) == 0) send_command(CMD_STEP, ADDR_W'($urandom), $urandom);
        break;
      end
    end
  endtask

  // Result side: check on every accepted transaction, then pick next cycle's ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result({out_ch.accumulator, out_ch.control_instr, out_ch.present_instr,
                         out_ch.halted, out_ch.read_data});
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int guard;
    sb = new();
    useful_cmds = 0;
    send_idle_pct = 36;
    recv_stall_pct = 53;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_STEP;
    in_ch.addr  <= '0;
    in_ch.data  <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed program: every function, both arithmetic extremes, CI wrap via JMP.
    send_command(CMD_LOAD, 5'd0,  32'hFFFF_FFFF);                 // STP with all bits set
    send_command(CMD_LOAD, 5'd1,  instr_word('0, FN_LDN, 20));
    send_command(CMD_LOAD, 5'd2,  instr_word('0, FN_SUB, 21));
    send_command(CMD_LOAD, 5'd3,  instr_word('0, FN_SUB_ALT, 22));
    send_command(CMD_LOAD, 5'd4,  instr_word('0, FN_STO, 23));
    send_command(CMD_LOAD, 5'd5,  instr_word('0, FN_CMP, 0));
    send_command(CMD_LOAD, 5'd7,  instr_word('0, FN_JRP, 24));
    send_command(CMD_LOAD, 5'd10, instr_word('0, FN_JMP, 25));
    send_command(CMD_LOAD, 5'd20, 32'h0000_0001);
    send_command(CMD_LOAD, 5'd21, 32'h8000_0000);
    send_command(CMD_LOAD, 5'd22, 32'hFFFF_FFFF);
    send_command(CMD_LOAD, 5'd24, 32'h0000_0002);
    send_command(CMD_LOAD, 5'd25, 32'hFFFF_FFFF);
    // LDN, SUB, SUB, STO leave the most negative value; CMP skips, JRP hops,
    // JMP sets CI to all ones so the next step wraps to word 0 and stops.
    repeat (8) send_command(CMD_STEP, '0, '0);
    send_command(CMD_STEP, 5'd31, 32'hFFFF_FFFF);                 // halted: no change
    send_command(CMD_READ, 5'd23, '0);
    send_command(CMD_RESTORE, '0, '0);                            // clears halt, undoes STO
    send_command(CMD_READ, 5'd23, '0);

    // Hold off once until the core is empty before the random part.
    wait_for_drain();

    while (useful_cmds < ITEM_GOAL) begin
      // Swap the idle mix a third of the way in, then drop it for the last third.
      if (send_idle_pct == 36 && useful_cmds >= ITEM_GOAL / 3) begin
        wait_for_drain();
        send_idle_pct = 53;
        recv_stall_pct = 36;
      end else if (send_idle_pct == 53 && useful_cmds >= 2 * ITEM_GOAL / 3) begin
        wait_for_drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(0, 99) < 80) begin
        run_random_program();
      end else begin
        repeat ($urandom_range(1, 4)) send_random_cmd();
      end
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end

    in_ch.valid <= 1'b0;
    for (guard = 0; guard < DRAIN_MAX && sb.pending() != 0; guard++) @(posedge clk);
    // Let a restore's worth of cycles pass to catch any stray result.
    repeat (2 * WORDS + 20) @(posedge clk);
    sb.flag_leftovers();

    $display("Ran %0d commands: %0d steps (%0d on a halted machine), %0d loads,",
             sb.n_checked, sb.n_by_cmd[CMD_STEP], sb.n_idle_steps, sb.n_by_cmd[CMD_LOAD]);
    $display("  %0d restores, %0d reads", sb.n_by_cmd[CMD_RESTORE], sb.n_by_cmd[CMD_READ]);
    $display("Functions JMP %0d JRP %0d LDN %0d STO %0d SUB %0d/%0d CMP %0d STP %0d, CI wraps %0d",
             sb.n_by_func[FN_JMP], sb.n_by_func[FN_JRP], sb.n_by_func[FN_LDN],
             sb.n_by_func[FN_STO], sb.n_by_func[FN_SUB], sb.n_by_func[FN_SUB_ALT],
             sb.n_by_func[FN_CMP], sb.n_by_func[FN_STP], sb.n_ci_wraps);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
